// ----- hdl/mpct_pkg.sv -----
// Shared types, constants and helpers for the MP configuration table parser.
package mpct_pkg;

  localparam logic [15:0] HDR_BYTES   = 16'd44;
  localparam logic [4:0]  PROC_LAST   = 5'd19;
  localparam logic [4:0]  OTHER_LAST  = 5'd7;
  localparam logic [3:0]  MAX_CPUS    = 4'd8;

  localparam logic [15:0] OFF_LEN_LO  = 16'd4;
  localparam logic [15:0] OFF_LEN_HI  = 16'd5;
  localparam logic [15:0] OFF_VERSION = 16'd6;
  localparam logic [15:0] SIG_BYTES   = 16'd4;

  localparam logic [7:0]  VERSION_A   = 8'd1;
  localparam logic [7:0]  VERSION_B   = 8'd4;

  localparam logic [2:0]  TYPE_PROC    = 3'd0;
  localparam logic [2:0]  TYPE_IOAPIC  = 3'd2;
  localparam logic [7:0]  TYPE_MAX     = 8'd4;
  localparam logic [2:0]  TYPE_UNKNOWN = 3'd5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIG   = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_BAD_TYPE  = 3'd4,
    ST_BAD_LEN   = 3'd5
  } status_t;

  typedef enum logic {
    EV_CPU     = 1'b0,
    EV_SUMMARY = 1'b1
  } event_kind_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h50;
      2'd1:    v = 8'h43;
      2'd2:    v = 8'h4D;
      default: v = 8'h50;
    endcase
    return v;
  endfunction

  // Keep the smallest nonzero code.
  function automatic status_t note_error(input status_t cur, input status_t code);
    status_t v;
    if (cur == ST_OK || code < cur) begin
      v = code;
    end else begin
      v = cur;
    end
    return v;
  endfunction

endpackage

// ----- hdl/mpct_if.sv -----
// Valid/ready channel interfaces for table bytes and parse results.
interface mpct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       first_byte;

  modport source (output valid, output table_byte, output first_byte, input ready);
  modport sink   (input valid, input table_byte, input first_byte, output ready);
endinterface

interface mpct_out_if;
  logic                valid;
  logic                ready;
  logic                event_kind;
  logic [7:0]          apic_id;
  logic [2:0]          cpu_slot;
  logic [3:0]          cpu_count;
  logic [7:0]          io_apic_id;
  logic                io_apic_seen;
  logic [2:0]          status;

  modport source (output valid, output event_kind, output apic_id, output cpu_slot,
                  output cpu_count, output io_apic_id, output io_apic_seen,
                  output status, input ready);
  modport sink   (input valid, input event_kind, input apic_id, input cpu_slot,
                  input cpu_count, input io_apic_id, input io_apic_seen,
                  input status, output ready);
endinterface

// ----- hdl/mp_config_table_parser.sv -----
// Streaming parser for an x86 multiprocessor configuration table.
//
//  channel  dir  payload                                         handshake
//  item     in   table_byte[7:0], first_byte                     valid/ready
//  result   out  event_kind, apic_id, cpu_slot, cpu_count,       valid/ready
//                io_apic_id, io_apic_seen, status
//
// One byte per cycle while item.ready is high; each accepted byte updates the parse
// state registers, and a result, if any, lands in the result register at the same edge.
// A full result register that is not taken holds item.ready low.
// rst clears the parse state and empties the result register.
module mp_config_table_parser (
  input  logic         clk,
  input  logic         rst,
  mpct_in_if.sink      item,
  mpct_out_if.source   result
);

  logic [15:0]         byte_offset;
  logic [15:0]         table_length;
  logic [7:0]          byte_sum;
  logic [4:0]          entry_remaining;
  logic [2:0]          entry_type;
  logic [3:0]          cpus_recorded;
  logic [7:0]          last_io_apic;
  logic                io_apic_flag;
  mpct_pkg::status_t   error_code;
  logic                active;

  logic [15:0]         byte_offset_next;
  logic [15:0]         table_length_next;
  logic [7:0]          byte_sum_next;
  logic [4:0]          entry_remaining_next;
  logic [2:0]          entry_type_next;
  logic [3:0]          cpus_recorded_next;
  logic [7:0]          last_io_apic_next;
  logic                io_apic_flag_next;
  mpct_pkg::status_t   error_code_next;
  logic                active_next;

  logic                res_valid;
  mpct_pkg::event_kind_t res_kind;
  logic [7:0]          res_apic;
  logic [2:0]          res_slot;
  logic [3:0]          res_count;
  logic [7:0]          res_io_id;
  logic                res_io_seen;
  mpct_pkg::status_t   res_status;

  logic                emit;
  mpct_pkg::event_kind_t emit_kind;
  logic [7:0]          emit_apic;
  logic [2:0]          emit_slot;
  logic [3:0]          emit_count;
  logic [7:0]          emit_io_id;
  logic                emit_io_seen;
  mpct_pkg::status_t   emit_status;

  logic                accept;
  logic [7:0]          b;
  logic [15:0]         off;
  logic [15:0]         end_len;
  logic                done;

  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign b          = item.table_byte;

  always_comb begin
    byte_offset_next     = byte_offset;
    table_length_next    = table_length;
    byte_sum_next        = byte_sum;
    entry_remaining_next = entry_remaining;
    entry_type_next      = entry_type;
    cpus_recorded_next   = cpus_recorded;
    last_io_apic_next    = last_io_apic;
    io_apic_flag_next    = io_apic_flag;
    error_code_next      = error_code;
    active_next          = active;
    emit         = 1'b0;
    emit_kind    = mpct_pkg::EV_CPU;
    emit_apic    = 8'd0;
    emit_slot    = 3'd0;
    emit_count   = 4'd0;
    emit_io_id   = 8'd0;
    emit_io_seen = 1'b0;
    emit_status  = mpct_pkg::ST_OK;
    off          = 16'd0;
    end_len      = mpct_pkg::HDR_BYTES;
    done         = 1'b0;

    if (accept && (item.first_byte || active)) begin
      if (item.first_byte) begin
        byte_offset_next     = 16'd0;
        table_length_next    = 16'd0;
        byte_sum_next        = 8'd0;
        entry_remaining_next = 5'd0;
        entry_type_next      = 3'd0;
        cpus_recorded_next   = 4'd0;
        last_io_apic_next    = 8'd0;
        io_apic_flag_next    = 1'b0;
        error_code_next      = mpct_pkg::ST_OK;
        active_next          = 1'b1;
      end
      off           = byte_offset_next;
      byte_sum_next = byte_sum_next + b;

      if (off < mpct_pkg::SIG_BYTES) begin
        if (b != mpct_pkg::sig_byte(off[1:0])) begin
          error_code_next = mpct_pkg::note_error(error_code_next, mpct_pkg::ST_BAD_SIG);
        end
      end else if (off == mpct_pkg::OFF_LEN_LO) begin
        table_length_next = {8'd0, b};
      end else if (off == mpct_pkg::OFF_LEN_HI) begin
        table_length_next = {b, table_length_next[7:0]};
        if ({b, table_length_next[7:0]} < mpct_pkg::HDR_BYTES) begin
          error_code_next = mpct_pkg::note_error(error_code_next, mpct_pkg::ST_BAD_LEN);
        end
      end else if (off == mpct_pkg::OFF_VERSION) begin
        if (b != mpct_pkg::VERSION_A && b != mpct_pkg::VERSION_B) begin
          error_code_next = mpct_pkg::note_error(error_code_next, mpct_pkg::ST_BAD_VER);
        end
      end

      end_len = (table_length_next < mpct_pkg::HDR_BYTES) ? mpct_pkg::HDR_BYTES
                                                           : table_length_next;
      done = (off >= mpct_pkg::OFF_LEN_HI) &&
             (({1'b0, off} + 17'd1) >= {1'b0, end_len});

      if (done) begin
        if (byte_sum_next != 8'd0) begin
          error_code_next = mpct_pkg::note_error(error_code_next, mpct_pkg::ST_BAD_SUM);
        end
        emit             = 1'b1;
        emit_kind        = mpct_pkg::EV_SUMMARY;
        emit_count       = cpus_recorded_next;
        emit_io_id       = last_io_apic_next;
        emit_io_seen     = io_apic_flag_next;
        emit_status      = error_code_next;
        active_next      = 1'b0;
        byte_offset_next = 16'd0;
      end else begin
        byte_offset_next = off + 16'd1;
        if (off >= mpct_pkg::HDR_BYTES) begin
          if (entry_remaining_next == 5'd0) begin
            if (b == 8'd0) begin
              entry_type_next      = mpct_pkg::TYPE_PROC;
              entry_remaining_next = mpct_pkg::PROC_LAST;
            end else begin
              if (b > mpct_pkg::TYPE_MAX) begin
                error_code_next = mpct_pkg::note_error(error_code_next,
                                                       mpct_pkg::ST_BAD_TYPE);
                entry_type_next = mpct_pkg::TYPE_UNKNOWN;
              end else begin
                entry_type_next = b[2:0];
              end
              entry_remaining_next = mpct_pkg::OTHER_LAST;
            end
          end else if (entry_type_next == mpct_pkg::TYPE_PROC &&
                       entry_remaining_next == mpct_pkg::PROC_LAST) begin
            entry_remaining_next = entry_remaining_next - 5'd1;
            if (cpus_recorded_next < mpct_pkg::MAX_CPUS) begin
              emit               = 1'b1;
              emit_kind          = mpct_pkg::EV_CPU;
              emit_apic          = b;
              emit_slot          = cpus_recorded_next[2:0];
              emit_count         = cpus_recorded_next + 4'd1;
              emit_io_id         = last_io_apic_next;
              emit_io_seen       = io_apic_flag_next;
              cpus_recorded_next = cpus_recorded_next + 4'd1;
            end
          end else begin
            if (entry_type_next == mpct_pkg::TYPE_IOAPIC &&
                entry_remaining_next == mpct_pkg::OTHER_LAST) begin
              last_io_apic_next = b;
              io_apic_flag_next = 1'b1;
            end
            entry_remaining_next = entry_remaining_next - 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= 16'd0;
      table_length    <= 16'd0;
      byte_sum        <= 8'd0;
      entry_remaining <= 5'd0;
      entry_type      <= 3'd0;
      cpus_recorded   <= 4'd0;
      last_io_apic    <= 8'd0;
      io_apic_flag    <= 1'b0;
      error_code      <= mpct_pkg::ST_OK;
      active          <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      byte_offset     <= byte_offset_next;
      table_length    <= table_length_next;
      byte_sum        <= byte_sum_next;
      entry_remaining <= entry_remaining_next;
      entry_type      <= entry_type_next;
      cpus_recorded   <= cpus_recorded_next;
      last_io_apic    <= last_io_apic_next;
      io_apic_flag    <= io_apic_flag_next;
      error_code      <= error_code_next;
      active          <= active_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_kind    <= emit_kind;
      res_apic    <= emit_apic;
      res_slot    <= emit_slot;
      res_count   <= emit_count;
      res_io_id   <= emit_io_id;
      res_io_seen <= emit_io_seen;
      res_status  <= emit_status;
    end
  end

  assign result.valid        = res_valid;
  assign result.event_kind   = res_kind;
  assign result.apic_id      = res_apic;
  assign result.cpu_slot     = res_slot;
  assign result.cpu_count    = res_count;
  assign result.io_apic_id   = res_io_id;
  assign result.io_apic_seen = res_io_seen;
  assign result.status       = res_status;

endmodule
